FILE: sv/ulte_pkg.sv
// Package for the USB low-speed transmit line encoder.
// Holds the symbol codes, the queue entry type, the sequencer phases and the CRC16 step.
// No dependencies; every module of the block imports it.
package ulte_pkg;

	localparam logic [1:0] SYM_J   = 2'd0;
	localparam logic [1:0] SYM_K   = 2'd1;
	localparam logic [1:0] SYM_SE0 = 2'd2;

	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [2:0]  STUFF_LIMIT = 3'd6;

	localparam int QUEUE_DEPTH = 2;
	localparam int QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// One classified byte, as the back end needs it.
	typedef struct packed {
		logic [7:0]  data;
		logic        sop;
		logic        eop;
		logic        crc_on;
		logic [15:0] crc;    // inverted CRC, valid when crc_on is set
	} ulte_cmd_t;

	typedef enum logic [2:0] {
		PH_SYNC,
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI,
		PH_EOP,
		PH_DONE
	} ulte_phase_t;

	// Reflected CRC16 over one byte, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = c_in;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = {1'b0, c[15:1]};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/ulte_pkt_if.sv
// Input channel of the line encoder: one packet byte and its framing flags per beat.
// Stand-alone interface; no package needed.
interface ulte_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_packet;
	logic       end_of_packet;
	logic       append_crc;

	modport source (output valid, data_byte, start_of_packet, end_of_packet, append_crc,
		input ready);
	modport sink (input valid, data_byte, start_of_packet, end_of_packet, append_crc,
		output ready);
endinterface

FILE: sv/ulte_sym_if.sv
// Output channel of the line encoder: one line symbol per beat.
// Stand-alone interface; no package needed.
interface ulte_sym_if;
	logic       valid;
	logic       ready;
	logic [1:0] line_state;
	logic       last_symbol;

	modport source (output valid, line_state, last_symbol, input ready);
	modport sink (input valid, line_state, last_symbol, output ready);
endinterface

FILE: sv/ulte_front.sv
// Front end: accepts packet bytes, keeps the running CRC16 and builds queue entries.
// Depends on ulte_pkg and ulte_pkt_if.
module ulte_front (
	input  logic             clk,
	input  logic             arst_n,
	ulte_pkt_if.sink         pkt,
	input  logic             q_full,
	output logic             q_push,
	output ulte_pkg::ulte_cmd_t q_entry
);
	import ulte_pkg::*;

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	assign pkt.ready = !q_full;
	assign q_push    = pkt.valid && !q_full;

	// The PID is not covered; a start of packet restarts the CRC instead.
	assign crc_next = pkt.start_of_packet ? CRC_INIT : crc_byte(crc_q, pkt.data_byte);

	always_comb begin
		q_entry.data   = pkt.data_byte;
		q_entry.sop    = pkt.start_of_packet;
		q_entry.eop    = pkt.end_of_packet;
		q_entry.crc_on = pkt.end_of_packet && pkt.append_crc;
		q_entry.crc    = crc_next ^ CRC_INIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (q_push) begin
			crc_q <= pkt.end_of_packet ? CRC_INIT : crc_next;
		end
	end

endmodule

FILE: sv/ulte_fifo.sv
// Short queue of classified bytes between the front end and the symbol sequencer.
// Depends on ulte_pkg for the entry type and depth.
module ulte_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ulte_pkg::ulte_cmd_t wr_entry,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output ulte_pkg::ulte_cmd_t head
);
	import ulte_pkg::*;

	ulte_cmd_t     mem_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   count_q;

	function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
		return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == (QW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/ulte_back.sv
// Back end: walks each queued byte through SYNC, NRZI data with bit stuffing, CRC and EOP,
// one line symbol per unstalled cycle into an output register; needs ulte_pkg, ulte_sym_if.
module ulte_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ulte_pkg::ulte_cmd_t head,
	output logic                pop,
	ulte_sym_if.source          sym
);
	import ulte_pkg::*;

	logic        busy_q;
	ulte_phase_t phase_q;
	logic [2:0]  cnt_q;
	logic        stuff_q;
	logic        level_q;
	logic [2:0]  ones_q;
	logic        valid_q;
	logic [1:0]  line_q;
	logic        last_q;

	ulte_phase_t eff_phase;
	logic [2:0]  eff_cnt;
	ulte_phase_t after_byte;
	ulte_phase_t phase_d;
	logic [7:0]  cur_byte;
	logic        bit_val;
	logic        load;
	logic        fire;

	logic [1:0]  sym_d;
	logic        last_d;
	logic        level_d;
	logic [2:0]  ones_d;
	logic        stuff_d;
	logic [2:0]  cnt_d;

	assign load = !valid_q || sym.ready;
	assign fire = load && head_valid;
	assign pop  = fire && last_d;

	// A fresh entry starts without a bubble: its first phase is decoded straight off the head.
	assign eff_phase = busy_q ? phase_q : (head.sop ? PH_SYNC : PH_DATA);
	assign eff_cnt   = busy_q ? cnt_q : 3'd0;

	always_comb begin
		case (eff_phase)
			PH_CRC_LO: cur_byte = head.crc[7:0];
			PH_CRC_HI: cur_byte = head.crc[15:8];
			default:   cur_byte = head.data;
		endcase
	end
	assign bit_val = cur_byte[eff_cnt];

	always_comb begin
		case (eff_phase)
			PH_DATA:   after_byte = head.eop ? (head.crc_on ? PH_CRC_LO : PH_EOP) : PH_DONE;
			PH_CRC_LO: after_byte = PH_CRC_HI;
			default:   after_byte = PH_EOP;
		endcase
	end

	// Next phase.
	always_comb begin
		phase_d = eff_phase;
		if (!stuff_q) begin
			case (eff_phase)
				PH_SYNC: begin
					if (eff_cnt == 3'd7) begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA, PH_CRC_LO, PH_CRC_HI: begin
					if (eff_cnt == 3'd7) begin
						phase_d = after_byte;
					end
				end
				default: phase_d = eff_phase;
			endcase
		end
	end

	// Symbol, line level, stuffing and counters.
	always_comb begin
		sym_d   = SYM_J;
		last_d  = 1'b0;
		level_d = level_q;
		ones_d  = ones_q;
		stuff_d = stuff_q;
		cnt_d   = eff_cnt;
		if (stuff_q) begin
			// A pending stuffed zero goes out before anything else.
			level_d = !level_q;
			ones_d  = 3'd0;
			stuff_d = 1'b0;
			sym_d   = {1'b0, !level_q};
			last_d  = (eff_phase == PH_DONE);
		end else begin
			case (eff_phase)
				PH_SYNC: begin
					sym_d = (eff_cnt == 3'd7 || !eff_cnt[0]) ? SYM_K : SYM_J;
					cnt_d = eff_cnt + 3'd1;
					if (eff_cnt == 3'd7) begin
						// SYNC ends on K, and its final one counts toward stuffing.
						level_d = 1'b1;
						ones_d  = 3'd1;
					end
				end
				PH_DATA, PH_CRC_LO, PH_CRC_HI: begin
					level_d = bit_val ? level_q : !level_q;
					ones_d  = bit_val ? ones_q + 3'd1 : 3'd0;
					stuff_d = (ones_d == STUFF_LIMIT);
					sym_d   = {1'b0, level_d};
					cnt_d   = eff_cnt + 3'd1;
					last_d  = (eff_cnt == 3'd7) && (after_byte == PH_DONE) && !stuff_d;
				end
				PH_EOP: begin
					sym_d = (eff_cnt == 3'd2) ? SYM_J : SYM_SE0;
					cnt_d = eff_cnt + 3'd1;
					if (eff_cnt == 3'd2) begin
						last_d  = 1'b1;
						level_d = 1'b0;
						ones_d  = 3'd0;
					end
				end
				default: begin
					sym_d = SYM_J;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_DATA;
			cnt_q   <= 3'd0;
			stuff_q <= 1'b0;
			level_q <= 1'b0;
			ones_q  <= 3'd0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				busy_q  <= !last_d;
				phase_q <= phase_d;
				cnt_q   <= (phase_d != eff_phase) ? 3'd0 : cnt_d;
				stuff_q <= stuff_d;
				level_q <= level_d;
				ones_q  <= ones_d;
			end
			if (load) begin
				valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			line_q <= sym_d;
			last_q <= last_d;
		end
	end

	assign sym.valid       = valid_q;
	assign sym.line_state  = line_q;
	assign sym.last_symbol = last_q;

endmodule

FILE: sv/usb_ls_tx_line_encoder_core.sv
// USB low-speed transmit line encoder. Packet bytes enter on pkt and leave as J/K/SE0 line
// symbols on sym, one symbol per beat, LSB first in NRZI with a zero stuffed after six ones.
// A start-of-packet byte is preceded by SYNC (8 symbols); an end-of-packet byte is followed
// by the optional inverted CRC16 of the bytes after the PID and by SE0, SE0, J. An ordinary
// byte yields its data symbols and any stuffed zeros, one symbol per cycle unless the output
// stalls; a start byte adds the SYNC, an end byte the EOP and any CRC. The front end takes a
// byte in any cycle in which its two-entry queue has room; the symbol output is registered,
// so the queue keeps taking bytes while the sink stalls, until it is full. Last_symbol marks
// the final symbol of each input byte. Depends on ulte_pkg and both channel interfaces.
module usb_ls_tx_line_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	ulte_pkt_if.sink   pkt,
	ulte_sym_if.source sym
);
	import ulte_pkg::*;

	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      head_valid;
	ulte_cmd_t wr_entry;
	ulte_cmd_t head;

	ulte_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (wr_entry)
	);

	ulte_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_entry   (wr_entry),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	ulte_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (q_pop),
		.sym        (sym)
	);

endmodule

FILE: verif/usb_ls_tx_line_encoder_core_tb.sv
// Testbench for usb_ls_tx_line_encoder_core: drives packet bytes and checks every line symbol.
// A scoreboard class predicts SYNC, NRZI, bit stuffing, CRC16 and EOP for each accepted byte.
// Depends on ulte_pkg, ulte_pkt_if, ulte_sym_if and the core itself.
`timescale 1ns / 1ps

module usb_ls_tx_line_encoder_core_tb;
	import ulte_pkg::*;

	localparam logic [15:0] CRC16_POLY  = 16'hA001;
	localparam logic [15:0] CRC16_SEED  = 16'hFFFF;
	localparam int          RUN_LIMIT   = 6;
	localparam int          ITEM_TARGET = 500;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          HOLD_CYCLES = 400;

	class line_symbol_scoreboard;
		typedef struct packed {
			logic [1:0] line;
			logic       last;
		} symbol_t;

		symbol_t     expected_q[$];
		bit          level;
		int          ones;
		logic [15:0] crc;
		int          mismatches;

		function new();
			level      = 1'b0;
			ones       = 0;
			crc        = CRC16_SEED;
			mismatches = 0;
		endfunction

		function void flag_error(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s", $realtime, msg);
			end
		endfunction

		function void push_symbol(logic [1:0] s);
			symbol_t e;
			e.line = s;
			e.last = 1'b0;
			expected_q.push_back(e);
		endfunction

		// NRZI: a zero flips the line, a one holds it.
		function void send_bit(bit b);
			if (!b) begin
				level = ~level;
			end
			push_symbol(level ? SYM_K : SYM_J);
		endfunction

		function void send_octet(logic [7:0] v);
			for (int i = 0; i < 8; i++) begin
				send_bit(v[i]);
				if (v[i]) begin
					ones++;
					if (ones >= RUN_LIMIT) begin
						send_bit(1'b0);
						ones = 0;
					end
				end else begin
					ones = 0;
				end
			end
		endfunction

		function void fold_crc(logic [7:0] v);
			bit fb;
			for (int i = 0; i < 8; i++) begin
				fb  = crc[0] ^ v[i];
				crc = {1'b0, crc[15:1]} ^ (fb ? CRC16_POLY : 16'h0000);
			end
		endfunction

		function void note_byte(logic [7:0] d, bit sop, bit eop, bit crc_on);
			logic [15:0] tail;
			if (sop) begin
				for (int i = 0; i < 7; i++) begin
					push_symbol((i % 2) ? SYM_J : SYM_K);
				end
				push_symbol(SYM_K);
				// The closing K of SYNC counts as a one toward stuffing.
				level = 1'b1;
				ones  = 1;
				crc   = CRC16_SEED;
			end else begin
				fold_crc(d);
			end
			send_octet(d);
			if (eop) begin
				if (crc_on) begin
					tail = ~crc;
					send_octet(tail[7:0]);
					send_octet(tail[15:8]);
				end
				push_symbol(SYM_SE0);
				push_symbol(SYM_SE0);
				push_symbol(SYM_J);
				level = 1'b0;
				ones  = 0;
				crc   = CRC16_SEED;
			end
			expected_q[expected_q.size() - 1].last = 1'b1;
		endfunction

		function void check(logic [1:0] line, logic last);
			symbol_t e;
			if (expected_q.size() == 0) begin
				flag_error($sformatf("symbol %0d last %0d with nothing expected", line, last));
				return;
			end
			e = expected_q.pop_front();
			if (e.line !== line || e.last !== last) begin
				flag_error($sformatf("expected symbol %0d last %0d, got symbol %0d last %0d",
					e.line, e.last, line, last));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   tx_idle_on;
	bit   rx_idle_on;
	bit   hold_req;
	int   cycle_count;

	line_symbol_scoreboard sb;

	ulte_pkt_if pkt_ch ();
	ulte_sym_if sym_ch ();

	usb_ls_tx_line_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.sym    (sym_ch)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && sym_ch.valid && sym_ch.ready) begin
			sb.check(sym_ch.line_state, sym_ch.last_symbol);
		end
	end

	// Symbol sink: random back-pressure, plus one long hold-off on request.
	initial begin
		int hold_left;
		hold_left    = 0;
		sym_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req <= 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				sym_ch.ready <= 1'b0;
			end else begin
				sym_ch.ready <= !(rx_idle_on && $urandom_range(0, 99) < 15);
			end
		end
	end

	function automatic logic [7:0] pick_octet();
		int r;
		r = $urandom_range(0, 7);
		if (r < 2) begin
			return 8'hFF;
		end else if (r == 2) begin
			return 8'h00;
		end
		return 8'($urandom);
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_byte(input logic [7:0] d, input bit sop, input bit eop, input bit crc_on);
		while (tx_idle_on && $urandom_range(0, 99) < 15) begin
			pkt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pkt_ch.valid           <= 1'b1;
		pkt_ch.data_byte       <= d;
		pkt_ch.start_of_packet <= sop;
		pkt_ch.end_of_packet   <= eop;
		pkt_ch.append_crc      <= crc_on;
		do begin
			@(posedge clk);
		end while (!pkt_ch.ready);
		sb.note_byte(d, sop, eop, crc_on);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		pkt_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
	endtask

	initial begin
		int sent;
		int pkt_idx;
		int n_data;
		bit last_crc;

		sb                     = new();
		cycle_count            = 0;
		tx_idle_on             = 1'b1;
		rx_idle_on             = 1'b1;
		hold_req               = 1'b0;
		arst_n                 = 1'b0;
		pkt_ch.valid           = 1'b0;
		pkt_ch.data_byte       = 8'h00;
		pkt_ch.start_of_packet = 1'b0;
		pkt_ch.end_of_packet   = 1'b0;
		pkt_ch.append_crc      = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Headless bytes straight after reset; the CRC request without an end is ignored.
		send_byte(8'h00, 1'b0, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b1, 1'b1);
		// Start and end together, with and without the CRC of no bytes.
		send_byte(8'hA5, 1'b1, 1'b1, 1'b0);
		send_byte(8'h2D, 1'b1, 1'b1, 1'b1);
		// The SYNC tail plus five ones in the PID forces an early stuff bit.
		send_byte(8'h1F, 1'b1, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0, 1'b0);
		send_byte(8'h7E, 1'b0, 1'b0, 1'b0);
		// Six ones open the byte, so a stuff bit comes before its two closing zeros.
		send_byte(8'h3F, 1'b0, 1'b1, 1'b0);
		send_byte(8'hC3, 1'b1, 1'b0, 1'b0);
		send_byte(8'h55, 1'b0, 1'b0, 1'b0);
		send_byte(8'hAA, 1'b0, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b1, 1'b1);
		send_byte(8'hE1, 1'b1, 1'b0, 1'b0);
		send_byte(8'hFC, 1'b0, 1'b1, 1'b0);
		// A new start in the middle of a packet restarts everything.
		send_byte(8'h69, 1'b1, 1'b0, 1'b0);
		send_byte(8'h4B, 1'b1, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b1, 1'b1);
		wait_drained();

		sent    = 0;
		pkt_idx = 0;
		while (sent < ITEM_TARGET) begin
			tx_idle_on = !(sent >= 150 && sent < 300);
			rx_idle_on <= !(sent >= 150 && sent < 300);
			if (pkt_idx == 10) begin
				hold_req <= 1'b1;
			end
			if (pkt_idx == 40) begin
				wait_drained();
			end
			if ($urandom_range(0, 9) == 0) begin
				// Noise: arbitrary framing flags on every beat.
				repeat ($urandom_range(1, 4)) begin
					send_byte(pick_octet(), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					sent++;
				end
			end else begin
				n_data = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 32)
					: $urandom_range(0, 6);
				last_crc = ($urandom_range(0, 3) != 0);
				send_byte(8'($urandom), 1'b1, n_data == 0, (n_data == 0) ? last_crc
					: 1'($urandom_range(0, 1)));
				sent++;
				for (int i = 1; i <= n_data; i++) begin
					send_byte(pick_octet(), 1'b0, i == n_data, (i == n_data) ? last_crc
						: 1'($urandom_range(0, 1)));
					sent++;
				end
			end
			pkt_idx++;
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (sb.expected_q.size() != 0) begin
			sb.flag_error($sformatf("%0d symbols never arrived", sb.expected_q.size()));
		end
		if (sb.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
